[rtl/dmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the direct-mapped cache read unit.
// No dependencies.
package dmc_pkg;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 8;
  localparam int TAG_W  = 8;
  localparam int CNT_W  = 32;

  localparam logic [TAG_W-1:0]  TAG_INVALID   = 8'hFF;
  localparam logic [DATA_W-1:0] PENALTY_RESET = 8'd10;

  // Request kinds carried on req_type
  localparam logic REQ_PRELOAD = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // capture request fields
    logic preload;   // write backing memory from the input beat
    logic lookup;    // tag compare, counter update, tag install on miss
    logic fill_clr;  // restart the line copy counter
    logic fill;      // advance the line copy by one byte
    logic line_rd;   // read the requested byte from the line store
    logic load_out;  // load the output register
  } dmc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic fill_last;
  } dmc_sts_t;

endpackage

[rtl/dmc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: backing memory, line store, tags, counters and output register.
// Depends on dmc_pkg; driven by dmc_ctrl commands.
module dmc_datapath #(
  parameter int LINE_BYTES = 16,
  parameter int NUM_LINES  = 8,
  parameter int MEM_BYTES  = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmc_pkg::dmc_cmd_t           cmd_i,
  output dmc_pkg::dmc_sts_t           sts_o,
  input  logic                        cfg_we_i,
  input  logic [dmc_pkg::DATA_W-1:0]  cfg_data_i,
  input  logic [dmc_pkg::ADDR_W-1:0]  address_i,
  input  logic [dmc_pkg::DATA_W-1:0]  write_data_i,
  output logic                        hit_o,
  output logic [dmc_pkg::DATA_W-1:0]  read_data_o,
  output logic [dmc_pkg::CNT_W-1:0]   miss_count_o,
  output logic [dmc_pkg::CNT_W-1:0]   access_count_o,
  output logic [dmc_pkg::CNT_W-1:0]   elapsed_time_o
);

  localparam int OFFW = $clog2(LINE_BYTES);
  localparam int IDXW = $clog2(NUM_LINES);
  localparam int MAW  = $clog2(MEM_BYTES);
  localparam int LAW  = IDXW + OFFW;

  localparam logic [OFFW:0] FILL_END = (OFFW+1)'(LINE_BYTES);

  logic [dmc_pkg::DATA_W-1:0] back_mem [MEM_BYTES];
  logic [dmc_pkg::DATA_W-1:0] line_mem [NUM_LINES*LINE_BYTES];

  logic [dmc_pkg::TAG_W-1:0] tag_q [NUM_LINES];
  logic [NUM_LINES-1:0]      valid_q;

  logic [MAW-1:0]             in_maddr;
  logic [MAW-1:0]             req_addr_q;
  logic [IDXW-1:0]            req_idx;
  logic [OFFW-1:0]            req_off;
  logic [dmc_pkg::TAG_W-1:0]  req_tag;
  logic                       hit;

  logic [OFFW:0]              fill_cnt_q, fill_cnt_d;
  logic [OFFW:0]              fill_prev;
  logic [dmc_pkg::DATA_W-1:0] mem_rd_q;
  logic [dmc_pkg::DATA_W-1:0] line_rd_q;
  logic                       hit_q;

  logic [dmc_pkg::DATA_W-1:0] penalty_q;
  logic [dmc_pkg::CNT_W-1:0]  miss_cnt_q, miss_cnt_d;
  logic [dmc_pkg::CNT_W-1:0]  acc_cnt_q, acc_cnt_d;
  logic [dmc_pkg::CNT_W-1:0]  elapsed_q, elapsed_d;
  logic [dmc_pkg::CNT_W:0]    elapsed_sum;

  logic                       out_hit_q;
  logic [dmc_pkg::DATA_W-1:0] out_data_q;
  logic [dmc_pkg::CNT_W-1:0]  out_miss_q, out_acc_q, out_time_q;

  // Addresses wrap modulo the backing memory size
  assign in_maddr = MAW'(32'(address_i));
  assign req_off  = req_addr_q[OFFW-1:0];
  assign req_idx  = IDXW'(32'(req_addr_q) >> OFFW);
  assign req_tag  = dmc_pkg::TAG_W'(32'(req_addr_q) >> (OFFW + IDXW));
  assign hit      = valid_q[req_idx] && (tag_q[req_idx] == req_tag);

  assign fill_prev = fill_cnt_q - (OFFW+1)'(1);

  assign sts_o.hit       = hit;
  assign sts_o.fill_last = (fill_cnt_q == FILL_END);

  // Saturating counter updates
  assign elapsed_sum = {1'b0, elapsed_q} + (dmc_pkg::CNT_W+1)'(penalty_q);

  always_comb begin
    miss_cnt_d = miss_cnt_q;
    acc_cnt_d  = acc_cnt_q;
    elapsed_d  = elapsed_q;
    if (cmd_i.lookup) begin
      if (acc_cnt_q != '1) begin
        acc_cnt_d = acc_cnt_q + dmc_pkg::CNT_W'(1);
      end
      if (!hit) begin
        if (miss_cnt_q != '1) begin
          miss_cnt_d = miss_cnt_q + dmc_pkg::CNT_W'(1);
        end
        elapsed_d = elapsed_sum[dmc_pkg::CNT_W] ? '1 : elapsed_sum[dmc_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    fill_cnt_d = fill_cnt_q;
    if (cmd_i.fill_clr) begin
      fill_cnt_d = '0;
    end else if (cmd_i.fill && !sts_o.fill_last) begin
      fill_cnt_d = fill_cnt_q + (OFFW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      penalty_q  <= dmc_pkg::PENALTY_RESET;
      miss_cnt_q <= '0;
      acc_cnt_q  <= '0;
      elapsed_q  <= '0;
      fill_cnt_q <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        tag_q[i] <= dmc_pkg::TAG_INVALID;
      end
    end else begin
      if (cfg_we_i) begin
        penalty_q <= cfg_data_i;
      end
      miss_cnt_q <= miss_cnt_d;
      acc_cnt_q  <= acc_cnt_d;
      elapsed_q  <= elapsed_d;
      fill_cnt_q <= fill_cnt_d;
      // install the tag up front; the line copy follows before any read
      if (cmd_i.lookup && !hit) begin
        tag_q[req_idx]   <= req_tag;
        valid_q[req_idx] <= 1'b1;
      end
    end
  end

  // Request capture and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_addr_q <= in_maddr;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit;
    end
    if (cmd_i.load_out) begin
      out_hit_q  <= hit_q;
      out_data_q <= line_rd_q;
      out_miss_q <= miss_cnt_q;
      out_acc_q  <= acc_cnt_q;
      out_time_q <= elapsed_q;
    end
  end

  // Backing memory: preload writes, line copy reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.preload) begin
      back_mem[in_maddr] <= write_data_i;
    end
    if (cmd_i.fill && !sts_o.fill_last) begin
      mem_rd_q <= back_mem[{req_addr_q[MAW-1:OFFW], fill_cnt_q[OFFW-1:0]}];
    end
  end

  // Line store: each byte written in the cycle after its backing read
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill && (fill_cnt_q != '0)) begin
      line_mem[LAW'({req_idx, fill_prev[OFFW-1:0]})] <= mem_rd_q;
    end
    if (cmd_i.line_rd) begin
      line_rd_q <= line_mem[LAW'({req_idx, req_off})];
    end
  end

  assign hit_o          = out_hit_q;
  assign read_data_o    = out_data_q;
  assign miss_count_o   = out_miss_q;
  assign access_count_o = out_acc_q;
  assign elapsed_time_o = out_time_q;

`ifndef SYNTHESIS
  a_miss_le_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_cnt_q <= acc_cnt_q)
    else $error("miss count exceeds access count");

  a_elapsed_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> elapsed_q >= $past(elapsed_q))
    else $error("elapsed time decreased");

  a_line_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |=> valid_q[req_idx] && (tag_q[req_idx] == req_tag))
    else $error("line not resident after lookup");
`endif

endmodule

[rtl/dmc_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the cache read unit: handshakes and sequencing.
// Depends on dmc_pkg; commands dmc_datapath.
module dmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  dmc_pkg::dmc_sts_t     sts_i,
  output dmc_pkg::dmc_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FILL,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept  = in_acc;
        cmd_o.preload = in_acc && (req_type_i == dmc_pkg::REQ_PRELOAD);
        if (in_acc && (req_type_i == dmc_pkg::REQ_READ)) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup   = 1'b1;
        cmd_o.fill_clr = 1'b1;
        state_d        = sts_i.hit ? S_READ : S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.line_rd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("output beat lost after load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("stalled output beat overwritten");

  a_read_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (req_type_i == dmc_pkg::REQ_READ)) |=> (state_q == S_LOOKUP))
    else $error("accepted read did not reach lookup");

  a_fill_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL && sts_i.fill_last) |=> (state_q == S_READ))
    else $error("line copy did not finish into read");
`endif

endmodule

[rtl/direct_mapped_cache_read_unit.sv]
`timescale 1ns / 1ps
// Top level of the direct-mapped cache read unit: controller plus datapath.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
//
// Direct-mapped read cache of NUM_LINES lines of LINE_BYTES bytes in front of a
// MEM_BYTES backing memory (all powers of two). A preload beat writes one byte
// of backing memory and gives no result; the unit stays idle for the next beat.
// A read beat on a hit passes through lookup, line store read and output load
// before the input is free again; a miss adds a line copy, one byte per cycle
// through the backing memory's single read port. One item is in work at a time;
// the result sits in an output register, so a new item may be accepted while it
// waits to be taken. Counters saturate at all ones. miss_penalty may be written
// only while the unit is idle.
module direct_mapped_cache_read_unit #(
  parameter int LINE_BYTES = 16,
  parameter int NUM_LINES  = 8,
  parameter int MEM_BYTES  = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [dmc_pkg::ADDR_W-1:0]  address_i,
  input  logic [dmc_pkg::DATA_W-1:0]  write_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [dmc_pkg::DATA_W-1:0]  read_data_o,
  output logic [dmc_pkg::CNT_W-1:0]   miss_count_o,
  output logic [dmc_pkg::CNT_W-1:0]   access_count_o,
  output logic [dmc_pkg::CNT_W-1:0]   elapsed_time_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmc_pkg::DATA_W-1:0]  cfg_data_i
);

  dmc_pkg::dmc_cmd_t cmd;
  dmc_pkg::dmc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmc_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .NUM_LINES  (NUM_LINES),
    .MEM_BYTES  (MEM_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .hit_o          (hit_o),
    .read_data_o    (read_data_o),
    .miss_count_o   (miss_count_o),
    .access_count_o (access_count_o),
    .elapsed_time_o (elapsed_time_o)
  );

endmodule
